// ===== src/fat_pkg.sv =====
// Shared constants, types and helpers for the first-and-last trace capture block.
`default_nettype none
package fat_pkg;

	localparam int NUM_ENTRIES  = 16;
	localparam int NUM_CHANNELS = 4;
	localparam int WORD_BITS    = 32;

	localparam int CH_W      = 2;
	localparam int LEVEL_W   = 4;
	localparam int COUNT_W   = 32;
	localparam int REQ_W     = 8;
	localparam int KIND_W    = 3;
	localparam int IN_WORD_W = 32;
	localparam int OUT_WORD_W = 32;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 2;
	localparam int OUT_PAD_W  = OUT_DATA_W - CH_W - COUNT_W - OUT_WORD_W;

	localparam int MASK_W   = 4;
	localparam int LEVELS_W = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	localparam int SLOT_W      = $clog2(NUM_ENTRIES);
	localparam int N_W         = $clog2(NUM_ENTRIES + 1);
	localparam int STORE_DEPTH = NUM_CHANNELS * NUM_ENTRIES;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [N_W-1:0]       num_t;
	typedef logic [COUNT_W-1:0]   count_t;
	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [CH_W-1:0]      chan_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE      = 3'd0,
		KIND_START      = 3'd1,
		KIND_STOP       = 3'd2,
		KIND_SUSPEND    = 3'd3,
		KIND_RESUME     = 3'd4,
		KIND_SHOW_FIRST = 3'd5,
		KIND_SHOW_LAST  = 3'd6
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRESENT_MASK = 1'b0,
		REG_WRITE_LEVELS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_EMPTY,
		B_READ,
		B_WAIT
	} back_state_t;

	// Store write request from the front end to both trace memories.
	typedef struct packed {
		logic  first_we;
		logic  ring_we;
		chan_t ch;
		slot_t first_slot;
		slot_t ring_slot;
		word_t data;
	} store_wr_t;

	// One show request; the back end walks entry, slot and remaining count.
	typedef struct packed {
		chan_t  ch;
		logic   ring;
		logic   empty;
		count_t entry;
		slot_t  slot;
		num_t   n;
	} show_cmd_t;

	typedef struct packed {
		chan_t                 ch;
		count_t                entry;
		logic [OUT_WORD_W-1:0] word;
		logic                  from_ring;
		logic                  empty_res;
		logic                  last;
	} result_t;

	function automatic addr_t store_addr(input chan_t ch, input slot_t slot);
		store_addr = ADDR_W'(ch) * ADDR_W'(NUM_ENTRIES) + ADDR_W'(slot);
	endfunction

	function automatic slot_t slot_inc(input slot_t slot);
		if (slot == SLOT_W'(NUM_ENTRIES - 1)) begin
			slot_inc = '0;
		end else begin
			slot_inc = slot + SLOT_W'(1);
		end
	endfunction

endpackage
`default_nettype wire

// ===== src/fat_front.sv =====
// Front end: configuration, per-channel capture state and classification of items.
`default_nettype none
module fat_front
	import fat_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
	input  wire logic [KIND_W-1:0]    s_axis_tuser,
	input  wire logic                 q_full,
	input  wire logic                 busy,
	output logic                      push,
	output show_cmd_t                 push_cmd,
	output store_wr_t                 store_wr
);

	logic [MASK_W-1:0]   present_q;
	logic [LEVELS_W-1:0] levels_q;
	count_t              count_q [NUM_CHANNELS];
	slot_t               pos_q   [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] en_q;
	logic [NUM_CHANNELS-1:0] susp_q;

	kind_t              kind;
	chan_t              ch;
	logic [LEVEL_W-1:0] level;
	word_t              word;
	logic [REQ_W-1:0]   req;
	logic               ch_ok;
	logic               acc;
	count_t             cnt;
	slot_t              pos;
	logic [LEVEL_W-1:0] ch_level;
	logic               wr_ok;
	num_t               req_c;
	num_t               n;
	num_t               pos_n;
	num_t               back_slot;
	logic               is_show;

	always_comb begin
		kind  = kind_t'(s_axis_tuser);
		ch    = s_axis_tdata[1:0];
		level = s_axis_tdata[5:2];
		word  = WORD_BITS'(s_axis_tdata[37:6]);
		req   = s_axis_tdata[45:38];
	end

	// Start is held off while a show is queued or running, so that the
	// stores it is reading cannot be overwritten underneath it.
	assign s_axis_tready = !q_full && !(kind == KIND_START && busy);

	assign ch_ok = ({1'b0, ch} < (CH_W + 1)'(NUM_CHANNELS)) && present_q[ch];
	assign acc   = s_axis_tvalid && s_axis_tready && ch_ok;

	always_comb begin
		cnt      = count_q[ch];
		pos      = pos_q[ch];
		ch_level = levels_q[LEVEL_W * ch +: LEVEL_W];
		wr_ok    = en_q[ch] && !susp_q[ch] && (level <= ch_level) && (cnt != '1);
		req_c    = (req > REQ_W'(NUM_ENTRIES)) ? N_W'(NUM_ENTRIES) : N_W'(req);
		n        = (cnt > COUNT_W'(req_c)) ? req_c : N_W'(cnt);
		pos_n    = N_W'(pos);
		// Slot of the oldest of the n newest entries, modulo the ring size.
		if (pos_n >= n) begin
			back_slot = pos_n - n;
		end else begin
			back_slot = pos_n + N_W'(NUM_ENTRIES) - n;
		end
		is_show = (kind == KIND_SHOW_FIRST) || (kind == KIND_SHOW_LAST);
	end

	always_comb begin
		push_cmd.ch    = ch;
		push_cmd.ring  = (kind == KIND_SHOW_LAST);
		push_cmd.empty = (cnt == '0);
		push_cmd.entry = (kind == KIND_SHOW_LAST) ? (cnt - COUNT_W'(n)) : '0;
		push_cmd.slot  = (kind == KIND_SHOW_LAST) ? SLOT_W'(back_slot) : '0;
		push_cmd.n     = n;
		push           = acc && is_show && ((cnt == '0) || (n != '0));
	end

	always_comb begin
		store_wr.ring_we    = acc && (kind == KIND_WRITE) && wr_ok;
		store_wr.first_we   = store_wr.ring_we && (cnt < COUNT_W'(NUM_ENTRIES));
		store_wr.ch         = ch;
		store_wr.first_slot = SLOT_W'(cnt);
		store_wr.ring_slot  = pos;
		store_wr.data       = word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			levels_q  <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PRESENT_MASK: present_q <= MASK_W'(cfg_data);
				REG_WRITE_LEVELS: levels_q  <= LEVELS_W'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				count_q[c] <= '0;
				pos_q[c]   <= '0;
			end
			en_q   <= '0;
			susp_q <= '0;
		end else if (acc) begin
			case (kind)
				KIND_WRITE: begin
					if (wr_ok) begin
						count_q[ch] <= cnt + COUNT_W'(1);
						pos_q[ch]   <= slot_inc(pos);
					end
				end
				KIND_START: begin
					count_q[ch] <= '0;
					pos_q[ch]   <= '0;
					en_q[ch]    <= 1'b1;
					susp_q[ch]  <= 1'b0;
				end
				KIND_STOP: begin
					en_q[ch]   <= 1'b0;
					susp_q[ch] <= 1'b0;
				end
				KIND_SUSPEND: susp_q[ch] <= 1'b1;
				KIND_RESUME:  susp_q[ch] <= 1'b0;
				KIND_SHOW_FIRST, KIND_SHOW_LAST: begin
					if (cnt != '0) begin
						en_q[ch]   <= 1'b0;
						susp_q[ch] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	a_start_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && kind == KIND_START) |-> !busy)
		else $error("start accepted while a show is pending");
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("show pushed into a full queue");
	a_first_with_ring: assert property (@(posedge clk) disable iff (!arst_n)
		store_wr.first_we |-> store_wr.ring_we)
		else $error("first store written without the ring");

endmodule
`default_nettype wire

// ===== src/fat_queue.sv =====
// Short queue of show requests between the front end and the back end.
`default_nettype none
module fat_queue
	import fat_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  show_cmd_t      push_cmd,
	input  wire logic      pop,
	output show_cmd_t      head,
	output logic           valid,
	output logic           full
);

	show_cmd_t            slots_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign valid   = (cnt_q != '0);
	assign full    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign head    = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/fat_back.sv =====
// Back end: trace memories and the sequencer that streams out show results.
`default_nettype none
module fat_back
	import fat_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  store_wr_t                  store_wr,
	input  show_cmd_t                  cmd,
	input  wire logic                  cmd_valid,
	output logic                       pop,
	output logic                       busy,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	output logic [OUT_USER_W-1:0]      m_axis_tuser,
	output logic                       m_axis_tlast
);

	word_t       first_mem [STORE_DEPTH];
	word_t       ring_mem  [STORE_DEPTH];
	word_t       first_rd_q;
	word_t       ring_rd_q;

	back_state_t state_q;
	back_state_t state_d;
	show_cmd_t   cmd_q;
	result_t     out_q;
	logic        out_valid_q;

	logic        out_free;
	logic        rd_en;
	logic        load_empty;
	logic        load_entry;
	addr_t       rd_addr;
	word_t       rd_word;

	assign out_free = !out_valid_q || m_axis_tready;
	assign rd_addr  = store_addr(cmd_q.ch, cmd_q.slot);
	assign rd_word  = cmd_q.ring ? ring_rd_q : first_rd_q;
	assign busy     = (state_q != B_IDLE);

	always_ff @(posedge clk) begin
		if (store_wr.first_we) begin
			first_mem[store_addr(store_wr.ch, store_wr.first_slot)] <= store_wr.data;
		end
		if (rd_en) begin
			first_rd_q <= first_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (store_wr.ring_we) begin
			ring_mem[store_addr(store_wr.ch, store_wr.ring_slot)] <= store_wr.data;
		end
		if (rd_en) begin
			ring_rd_q <= ring_mem[rd_addr];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					state_d = cmd.empty ? B_EMPTY : B_READ;
				end
			end
			B_EMPTY: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			B_READ: begin
				if (out_free) begin
					state_d = B_WAIT;
				end
			end
			B_WAIT:  state_d = (cmd_q.n == N_W'(1)) ? B_IDLE : B_READ;
			default: state_d = B_IDLE;
		endcase
	end

	// A read is issued only when the output register is free, so the read data
	// can always be loaded into it in the B_WAIT state that follows.
	always_comb begin
		pop        = 1'b0;
		rd_en      = 1'b0;
		load_empty = 1'b0;
		load_entry = 1'b0;
		case (state_q)
			B_IDLE:  pop        = cmd_valid;
			B_EMPTY: load_empty = out_free;
			B_READ:  rd_en      = out_free;
			B_WAIT:  load_entry = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_empty || load_entry) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
		end else if (load_entry) begin
			cmd_q.entry <= cmd_q.entry + COUNT_W'(1);
			cmd_q.slot  <= slot_inc(cmd_q.slot);
			cmd_q.n     <= cmd_q.n - N_W'(1);
		end
		if (load_empty) begin
			out_q.ch        <= cmd_q.ch;
			out_q.entry     <= '0;
			out_q.word      <= '0;
			out_q.from_ring <= cmd_q.ring;
			out_q.empty_res <= 1'b1;
			out_q.last      <= 1'b1;
		end else if (load_entry) begin
			out_q.ch        <= cmd_q.ch;
			out_q.entry     <= cmd_q.entry;
			out_q.word      <= OUT_WORD_W'(rd_word);
			out_q.from_ring <= cmd_q.ring;
			out_q.empty_res <= 1'b0;
			out_q.last      <= (cmd_q.n == N_W'(1));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {OUT_PAD_W'(0), out_q.word, out_q.entry, out_q.ch};
	assign m_axis_tuser  = {out_q.empty_res, out_q.from_ring};
	assign m_axis_tlast  = out_q.last;

	a_wait_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WAIT) |-> !out_valid_q)
		else $error("read data arrived while the output register was full");
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.empty_res) |-> out_q.last)
		else $error("empty result not marked last");
	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_IDLE && cmd_valid) |=> (state_q != B_IDLE))
		else $error("queued show was not taken up");

endmodule
`default_nettype wire

// ===== src/first_and_last_trace_capture.sv =====
// Top level of the first-and-last trace capture block.
//
// Four trace channels each record accepted writes into a first-N store and a
// last-N ring (16 entries each) and replay them on a show request. Writes and
// control items (start, stop, suspend, resume) are taken one per cycle. A show
// is classified in the front end, queued (two deep) and replayed by the back
// end one entry at a time, since each entry costs a registered memory read
// followed by a load of the output register; an empty show gives its single
// result from the B_EMPTY state once the output register is free. Every
// item is held off while the show queue is full, and a start item is also
// held off while any show is queued or being replayed. A show whose channel
// has writes but whose requested count is zero only stops the channel and
// gives no result. There is no clearing pass after reset.
`default_nettype none
module first_and_last_trace_capture
	import fat_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// channel[1:0], level[5:2], trace_word[37:6], show_count[45:38], zeros above
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind[2:0]
	input  wire logic [KIND_W-1:0]     s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// out_channel[1:0], entry_number[33:2], shown_word[65:34], zeros above
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// from_ring[0], empty_res[1]
	output logic [OUT_USER_W-1:0]      m_axis_tuser,
	output logic                       m_axis_tlast
);

	logic      q_full;
	logic      q_valid;
	logic      push;
	logic      pop;
	logic      back_busy;
	logic      busy;
	show_cmd_t push_cmd;
	show_cmd_t head;
	store_wr_t store_wr;

	assign busy = q_valid || back_busy;

	fat_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.busy          (busy),
		.push          (push),
		.push_cmd      (push_cmd),
		.store_wr      (store_wr)
	);

	fat_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.valid    (q_valid),
		.full     (q_full)
	);

	fat_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.store_wr      (store_wr),
		.cmd           (head),
		.cmd_valid     (q_valid),
		.pop           (pop),
		.busy          (back_busy),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
`default_nettype wire

// ===== sim/first_and_last_trace_capture_tb.sv =====
// Self-checking testbench for the first-and-last trace capture block.
`default_nettype none
module first_and_last_trace_capture_tb;
	import fat_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
	localparam int IDLE_PERCENT = 14;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		chan_t  ch;
		count_t entry;
		word_t  word;
		logic   ring;
		logic   empty;
		logic   last;
	} trace_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [KIND_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic m_axis_tlast;

	// Shadow of the block: registers, per-channel counters and both stores.
	logic [MASK_W-1:0] present_mask = '0;
	logic [LEVELS_W-1:0] write_levels = '0;
	count_t write_count [NUM_CHANNELS];
	logic capture_on [NUM_CHANNELS];
	logic capture_paused [NUM_CHANNELS];
	word_t first_words [NUM_CHANNELS][NUM_ENTRIES];
	word_t ring_words [NUM_CHANNELS][NUM_ENTRIES];

	trace_result_t expected_entries [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	logic calm_run = 1'b0;

	first_and_last_trace_capture i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= calm_run || ($urandom_range(99) >= IDLE_PERCENT);
	end

	function automatic void clear_shadow();
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			write_count[c] = '0;
			capture_on[c] = 1'b0;
			capture_paused[c] = 1'b0;
		end
	endfunction

	function automatic void predict_trace_item(input logic [KIND_W-1:0] kind, input chan_t ch,
			input logic [LEVEL_W-1:0] level, input word_t word, input logic [REQ_W-1:0] req);
		count_t cnt;
		logic [LEVEL_W-1:0] ch_level;
		logic ring;
		count_t n;
		count_t first_entry;
		count_t e;
		trace_result_t res;
		if (!present_mask[ch]) begin
			return;
		end
		cnt = write_count[ch];
		ch_level = write_levels[LEVEL_W*ch +: LEVEL_W];
		case (kind)
			KIND_WRITE: begin
				if (capture_on[ch] && !capture_paused[ch] && level <= ch_level &&
						cnt != '1) begin
					if (cnt < NUM_ENTRIES) begin
						first_words[ch][cnt] = word;
					end
					ring_words[ch][cnt % NUM_ENTRIES] = word;
					write_count[ch] = cnt + 1;
				end
			end
			KIND_START: begin
				write_count[ch] = '0;
				capture_on[ch] = 1'b1;
				capture_paused[ch] = 1'b0;
			end
			KIND_STOP: begin
				capture_on[ch] = 1'b0;
				capture_paused[ch] = 1'b0;
			end
			KIND_SUSPEND: capture_paused[ch] = 1'b1;
			KIND_RESUME: capture_paused[ch] = 1'b0;
			KIND_SHOW_FIRST, KIND_SHOW_LAST: begin
				ring = (kind == KIND_SHOW_LAST);
				if (cnt == 0) begin
					// An empty channel answers once and keeps capturing.
					res = '{ch: ch, entry: '0, word: '0, ring: ring, empty: 1'b1, last: 1'b1};
					expected_entries.push_back(res);
				end else begin
					capture_on[ch] = 1'b0;
					capture_paused[ch] = 1'b0;
					n = (req > NUM_ENTRIES) ? count_t'(NUM_ENTRIES) : count_t'(req);
					if (cnt < n) begin
						n = cnt;
					end
					first_entry = ring ? cnt - n : '0;
					for (count_t i = 0; i < n; i++) begin
						e = first_entry + i;
						res.ch = ch;
						res.entry = e;
						res.word = ring ? ring_words[ch][e % NUM_ENTRIES]
							: first_words[ch][e % NUM_ENTRIES];
						res.ring = ring;
						res.empty = 1'b0;
						res.last = (i + 1 == n);
						expected_entries.push_back(res);
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report_field(input string name, input logic [COUNT_W-1:0] want,
			input logic [COUNT_W-1:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		trace_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_entries.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, actual %h %h %b",
					$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end else begin
				want = expected_entries.pop_front();
				report_field("out_channel", COUNT_W'(want.ch), COUNT_W'(m_axis_tdata[1:0]));
				report_field("entry_number", want.entry, m_axis_tdata[33:2]);
				report_field("shown_word", want.word, m_axis_tdata[65:34]);
				report_field("from_ring", COUNT_W'(want.ring), COUNT_W'(m_axis_tuser[0]));
				report_field("empty_res", COUNT_W'(want.empty), COUNT_W'(m_axis_tuser[1]));
				report_field("last", COUNT_W'(want.last), COUNT_W'(m_axis_tlast));
			end
		end
	end

	// Presents one item and returns at the edge where it is accepted; tvalid stays
	// high so that a following item can go out back to back.
	task automatic send_trace_item(input logic [KIND_W-1:0] kind, input chan_t ch,
			input logic [LEVEL_W-1:0] level, input word_t word, input logic [REQ_W-1:0] req);
		if (!calm_run && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, req, word, level, ch};
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		predict_trace_item(kind, ch, level, word, req);
	endtask

	task automatic send_random_fields(input logic [KIND_W-1:0] kind, input chan_t ch);
		send_trace_item(kind, ch, LEVEL_W'($urandom_range(15)), $urandom(),
			REQ_W'($urandom_range(255)));
	endtask

	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		while (expected_entries.size() != 0) begin
			@(posedge clk);
		end
		// A show with a zero count gives no result but may still be in flight.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		settle_block();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PRESENT_MASK: present_mask = value[MASK_W-1:0];
			REG_WRITE_LEVELS: write_levels = value[LEVELS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic test_empty_show();
		send_trace_item(KIND_SHOW_FIRST, 2'd0, 4'd0, 32'h0, 8'd5);
		send_trace_item(KIND_SHOW_LAST, 2'd1, 4'd15, 32'hFFFF_FFFF, 8'd0);
	endtask

	task automatic test_write_filters();
		send_trace_item(KIND_WRITE, 2'd0, 4'd0, 32'h1234_5678, 8'd0);
		send_trace_item(KIND_START, 2'd0, 4'd0, 32'h0, 8'd0);
		send_trace_item(KIND_WRITE, 2'd0, 4'd15, 32'hFFFF_FFFF, 8'd255);
		send_trace_item(KIND_WRITE, 2'd0, 4'd0, 32'h0, 8'd0);
		send_trace_item(KIND_START, 2'd1, 4'd0, 32'h0, 8'd0);
		send_trace_item(KIND_WRITE, 2'd1, 4'd1, 32'hDEAD_BEEF, 8'd0);
		send_trace_item(KIND_WRITE, 2'd1, 4'd0, 32'hA5A5_A5A5, 8'd0);
		send_trace_item(KIND_SUSPEND, 2'd1, 4'd0, 32'h0, 8'd0);
		send_trace_item(KIND_WRITE, 2'd1, 4'd0, 32'h0BAD_0BAD, 8'd0);
		send_trace_item(KIND_RESUME, 2'd1, 4'd0, 32'h0, 8'd0);
		send_trace_item(KIND_WRITE, 2'd1, 4'd0, 32'h5A5A_5A5A, 8'd0);
	endtask

	task automatic test_show_clamp_and_stop();
		send_trace_item(KIND_SHOW_LAST, 2'd0, 4'd0, 32'h0, 8'd255);
		send_trace_item(KIND_WRITE, 2'd0, 4'd0, 32'h7777_7777, 8'd0);
		// A zero count on a channel with entries stops it without any result.
		send_trace_item(KIND_SHOW_FIRST, 2'd1, 4'd0, 32'h0, 8'd0);
		send_trace_item(KIND_WRITE, 2'd1, 4'd0, 32'h6666_6666, 8'd0);
		send_trace_item(KIND_SHOW_FIRST, 2'd1, 4'd0, 32'h0, 8'd1);
	endtask

	task automatic test_control_corners();
		send_trace_item(KIND_SUSPEND, 2'd2, 4'd0, 32'h0, 8'd0);
		send_trace_item(KIND_RESUME, 2'd2, 4'd0, 32'h0, 8'd0);
		send_trace_item(KIND_UNUSED, 2'd0, 4'd0, 32'h0, 8'd3);
		send_trace_item(KIND_START, 2'd3, 4'd0, 32'h0, 8'd0);
		send_trace_item(KIND_WRITE, 2'd3, 4'd3, 32'hC0DE_CAFE, 8'd0);
		send_trace_item(KIND_STOP, 2'd3, 4'd0, 32'h0, 8'd0);
		send_trace_item(KIND_WRITE, 2'd3, 4'd0, 32'h1111_1111, 8'd0);
		send_trace_item(KIND_SHOW_FIRST, 2'd3, 4'd0, 32'h0, 8'd16);
	endtask

	task automatic test_absent_channel();
		write_register(REG_PRESENT_MASK, CFG_W'(4'b0101));
		send_trace_item(KIND_SHOW_LAST, 2'd1, 4'd0, 32'h0, 8'd4);
		send_trace_item(KIND_START, 2'd3, 4'd0, 32'h0, 8'd0);
		send_trace_item(KIND_SHOW_FIRST, 2'd3, 4'd0, 32'h0, 8'd4);
	endtask

	// Start, a burst of mostly accepted writes with some control mixed in, then
	// one or two shows of the same channel.
	task automatic test_capture_sessions(input int item_goal);
		int sent;
		int n_writes;
		int pick;
		chan_t ch;
		logic [LEVEL_W-1:0] ch_level;
		logic [KIND_W-1:0] show_kind;
		logic [REQ_W-1:0] req;
		sent = 0;
		while (sent < item_goal && present_mask != '0) begin
			do begin
				ch = chan_t'($urandom_range(3));
			end while (!present_mask[ch]);
			ch_level = write_levels[LEVEL_W*ch +: LEVEL_W];
			send_random_fields(KIND_START, ch);
			n_writes = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(18);
			for (int i = 0; i < n_writes; i++) begin
				pick = $urandom_range(99);
				if (pick < 4) begin
					send_random_fields(KIND_SUSPEND, ch);
				end else if (pick < 10) begin
					send_random_fields(KIND_RESUME, ch);
				end else if (pick < 16) begin
					send_random_fields(KIND_WRITE, chan_t'($urandom_range(3)));
				end else if (pick < 22) begin
					send_random_fields(KIND_WRITE, ch);
				end else begin
					send_trace_item(KIND_WRITE, ch, LEVEL_W'($urandom_range(ch_level)),
						$urandom(), REQ_W'($urandom_range(255)));
				end
			end
			sent += n_writes + 1;
			for (int s = 0; s < (($urandom_range(4) == 0) ? 2 : 1); s++) begin
				show_kind = $urandom_range(1) ? KIND_SHOW_LAST : KIND_SHOW_FIRST;
				pick = $urandom_range(9);
				if (pick == 0) begin
					req = '0;
				end else if (pick == 1) begin
					req = '1;
				end else if (pick == 2) begin
					req = REQ_W'($urandom_range(255));
				end else begin
					req = REQ_W'($urandom_range(1, 20));
				end
				send_trace_item(show_kind, ch, LEVEL_W'($urandom_range(15)), $urandom(), req);
				sent++;
			end
		end
	endtask

	task automatic test_random_noise(input int n_items);
		for (int i = 0; i < n_items; i++) begin
			send_random_fields(KIND_W'($urandom_range(7)), chan_t'($urandom_range(3)));
		end
	endtask

	initial begin
		clear_shadow();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_register(REG_PRESENT_MASK, CFG_W'(4'hF));
		write_register(REG_WRITE_LEVELS, 16'h370F);
		test_empty_show();
		test_write_filters();
		test_show_clamp_and_stop();
		test_control_corners();
		test_absent_channel();

		// Both sides run without any idling through this phase.
		write_register(REG_PRESENT_MASK, CFG_W'(4'hF));
		write_register(REG_WRITE_LEVELS, 16'hFFFF);
		calm_run = 1'b1;
		test_capture_sessions(25);
		calm_run = 1'b0;

		write_register(REG_WRITE_LEVELS, CFG_W'($urandom_range(16'hFFFF)));
		test_capture_sessions(25);
		test_random_noise(20);

		write_register(REG_PRESENT_MASK, CFG_W'($urandom_range(1, 15)));
		write_register(REG_WRITE_LEVELS, 16'h0000);
		test_capture_sessions(25);

		write_register(REG_PRESENT_MASK, CFG_W'(4'h0));
		test_random_noise(10);

		settle_block();
		if (mismatch_count == 0 && expected_entries.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
src/fat_pkg.sv
src/fat_front.sv
src/fat_queue.sv
src/fat_back.sv
src/first_and_last_trace_capture.sv
sim/first_and_last_trace_capture_tb.sv
